[hdl/efe_pkg.sv]
// Shared types, constants and the CRC byte update for the escaped frame encoder.
package efe_pkg;

  typedef struct packed {
    logic        cmd;
    logic [15:0] payload_length;
    logic [7:0]  frame_command;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  status;
    logic        frame_end;
    logic [15:0] encoded_length;
  } result_t;

  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_LONG = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_ORPHAN   = 2'd3;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_START_MARKER  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_MARKER = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD   = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ENCODED   = CFG_INDEX_W'(3);

  localparam logic [7:0]  START_MARKER_RST  = 8'd126;
  localparam logic [7:0]  ESCAPE_MARKER_RST = 8'd125;
  localparam logic [15:0] MAX_PAYLOAD_RST   = 16'd1024;
  localparam logic [15:0] MAX_ENCODED_RST   = 16'd2048;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] HEADER_LEN = 16'd5;

  localparam int QUEUE_DEPTH_DEF = 2;

  // Result slots of one job, in transmit order
  localparam int NUM_SLOTS = 10;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_START  = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] SLOT_LEN_HI = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_LEN_LO = SLOT_W'(2);
  localparam logic [SLOT_W-1:0] SLOT_SEQ    = SLOT_W'(3);
  localparam logic [SLOT_W-1:0] SLOT_CMD    = SLOT_W'(4);
  localparam logic [SLOT_W-1:0] SLOT_ESC    = SLOT_W'(5);
  localparam logic [SLOT_W-1:0] SLOT_DATA   = SLOT_W'(6);
  localparam logic [SLOT_W-1:0] SLOT_CRC_HI = SLOT_W'(7);
  localparam logic [SLOT_W-1:0] SLOT_CRC_LO = SLOT_W'(8);
  localparam logic [SLOT_W-1:0] SLOT_ERR    = SLOT_W'(9);

  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

  localparam slot_mask_t MASK_HEADER = (slot_mask_t'(1) << SLOT_START)
                                     | (slot_mask_t'(1) << SLOT_LEN_HI)
                                     | (slot_mask_t'(1) << SLOT_LEN_LO)
                                     | (slot_mask_t'(1) << SLOT_SEQ)
                                     | (slot_mask_t'(1) << SLOT_CMD);
  localparam slot_mask_t MASK_ESC    = slot_mask_t'(1) << SLOT_ESC;
  localparam slot_mask_t MASK_DATA   = slot_mask_t'(1) << SLOT_DATA;
  localparam slot_mask_t MASK_CRC    = (slot_mask_t'(1) << SLOT_CRC_HI)
                                     | (slot_mask_t'(1) << SLOT_CRC_LO);
  localparam slot_mask_t MASK_ERR    = slot_mask_t'(1) << SLOT_ERR;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [15:0] length;
    logic [7:0]  seq;
    logic [7:0]  command;
    logic [7:0]  esc_byte;
    logic [7:0]  data_byte;
    logic [15:0] crc;
    logic [15:0] enc_len;
    logic [1:0]  err_status;
  } job_t;

  typedef struct packed {
    slot_mask_t mask;
    job_t       job;
  } entry_t;

  // CRC-16 poly 0x1021, MSB first, one byte folded in with a flat XOR network
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = crc[15:8] ^ b;
    x = x ^ (x >> 4);
    return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
  endfunction

endpackage

[hdl/efe_front.sv]
// Front end: config registers, item acceptance, frame state and job classification.
module efe_front import efe_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  item_t                  item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   q_full,
  output logic                   q_push,
  output entry_t                 q_entry
);

  logic [7:0]  start_marker;
  logic [7:0]  escape_marker;
  logic [15:0] max_payload;
  logic [15:0] max_encoded;

  logic [7:0]  seq, seq_next;
  logic [15:0] crc, crc_next;
  logic [15:0] remaining, remaining_next;
  logic [15:0] pos, pos_next;
  logic        open, open_next;
  logic        discarding, discarding_next;

  logic        accept;
  logic [15:0] crc_len, crc_hdr, crc_dat;
  logic        is_esc;
  logic [15:0] rem_dec;
  logic [15:0] pos1, pos2;
  logic [16:0] lim;

  assign item_ready = !q_full;
  assign cfg_ready  = 1'b1;
  assign accept     = item_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker  <= START_MARKER_RST;
      escape_marker <= ESCAPE_MARKER_RST;
      max_payload   <= MAX_PAYLOAD_RST;
      max_encoded   <= MAX_ENCODED_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_START_MARKER:  start_marker  <= cfg_data[7:0];
        REG_ESCAPE_MARKER: escape_marker <= cfg_data[7:0];
        REG_MAX_PAYLOAD:   max_payload   <= cfg_data;
        REG_MAX_ENCODED:   max_encoded   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign crc_len = crc_byte(crc_byte(CRC_INIT, item.payload_length[15:8]),
                            item.payload_length[7:0]);
  assign crc_hdr = crc_byte(crc_byte(crc_len, seq), item.frame_command);
  assign crc_dat = crc_byte(crc, item.data_byte);
  assign is_esc  = (item.data_byte == start_marker) || (item.data_byte == escape_marker);
  assign rem_dec = remaining - 16'd1;
  assign pos1    = pos + {15'd0, is_esc};
  assign pos2    = pos1 + 16'd1;
  assign lim     = {1'b0, max_encoded};

  always_comb begin
    seq_next        = seq;
    crc_next        = crc;
    remaining_next  = remaining;
    pos_next        = pos;
    open_next       = open;
    discarding_next = discarding;
    q_push          = 1'b0;

    q_entry.mask           = '0;
    q_entry.job.start_byte = start_marker;
    q_entry.job.length     = item.payload_length;
    q_entry.job.seq        = seq;
    q_entry.job.command    = item.frame_command;
    q_entry.job.esc_byte   = escape_marker;
    q_entry.job.data_byte  = item.data_byte;
    q_entry.job.crc        = crc_dat;
    q_entry.job.enc_len    = pos2 + 16'd2;
    q_entry.job.err_status = ST_OVERFLOW;

    if (accept) begin
      if (item.cmd == CMD_BEGIN) begin
        open_next       = 1'b0;
        discarding_next = 1'b0;
        remaining_next  = '0;
        pos_next        = '0;
        crc_next        = CRC_INIT;
        q_push          = 1'b1;
        if (item.payload_length > max_payload) begin
          q_entry.mask           = MASK_ERR;
          q_entry.job.err_status = ST_TOO_LONG;
        end else begin
          q_entry.mask   = MASK_HEADER;
          crc_next       = crc_hdr;
          pos_next       = HEADER_LEN;
          remaining_next = item.payload_length;
          open_next      = 1'b1;
          if (item.payload_length == 16'd0) begin
            open_next = 1'b0;
            crc_next  = CRC_INIT;
            pos_next  = '0;
            if ({1'b0, HEADER_LEN} + 17'd2 > lim) begin
              q_entry.mask = MASK_HEADER | MASK_ERR;
            end else begin
              q_entry.mask        = MASK_HEADER | MASK_CRC;
              q_entry.job.crc     = crc_hdr;
              q_entry.job.enc_len = HEADER_LEN + 16'd2;
              seq_next            = seq + 8'd1;
            end
          end
        end
      end else if (discarding) begin
        // Swallow the rest of an aborted frame
        if (remaining != 16'd0) begin
          remaining_next = rem_dec;
        end
        if (remaining_next == 16'd0) begin
          discarding_next = 1'b0;
        end
      end else if (!open) begin
        q_push                 = 1'b1;
        q_entry.mask           = MASK_ERR;
        q_entry.job.err_status = ST_ORPHAN;
      end else begin
        q_push         = 1'b1;
        remaining_next = rem_dec;
        if (is_esc && ({1'b0, pos} + 17'd4 > lim)) begin
          q_entry.mask    = MASK_ERR;
          open_next       = 1'b0;
          discarding_next = rem_dec != 16'd0;
          crc_next        = CRC_INIT;
          pos_next        = '0;
        end else if ({1'b0, pos1} + 17'd3 > lim) begin
          q_entry.mask    = (is_esc ? MASK_ESC : '0) | MASK_ERR;
          open_next       = 1'b0;
          discarding_next = rem_dec != 16'd0;
          crc_next        = CRC_INIT;
          pos_next        = '0;
        end else begin
          q_entry.mask = (is_esc ? MASK_ESC : '0) | MASK_DATA;
          crc_next     = crc_dat;
          pos_next     = pos2;
          if (rem_dec == 16'd0) begin
            open_next       = 1'b0;
            discarding_next = 1'b0;
            crc_next        = CRC_INIT;
            pos_next        = '0;
            if ({1'b0, pos2} + 17'd2 > lim) begin
              q_entry.mask = q_entry.mask | MASK_ERR;
            end else begin
              q_entry.mask = q_entry.mask | MASK_CRC;
              seq_next     = seq + 8'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq        <= '0;
      crc        <= CRC_INIT;
      remaining  <= '0;
      pos        <= '0;
      open       <= 1'b0;
      discarding <= 1'b0;
    end else begin
      seq        <= seq_next;
      crc        <= crc_next;
      remaining  <= remaining_next;
      pos        <= pos_next;
      open       <= open_next;
      discarding <= discarding_next;
    end
  end

endmodule

[hdl/efe_queue.sv]
// Short job queue between the front and back ends.
module efe_queue import efe_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   empty,
  output entry_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[hdl/efe_back.sv]
// Back end: walks the slots of each job and drives the registered result channel.
module efe_back import efe_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  entry_t  q_head,
  output logic    q_pop,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  job_t              cur;
  slot_mask_t        cur_mask;
  slot_mask_t        mask_after;
  logic [SLOT_W-1:0] idx;
  logic              out_free;
  logic              emit;
  result_t           result_next;

  assign out_free = !result_valid || result_ready;
  assign emit     = out_free && (cur_mask != '0);

  // Lowest pending slot goes out first
  always_comb begin
    idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (cur_mask[i]) begin
        idx = SLOT_W'(i);
      end
    end
  end

  assign mask_after = emit ? (cur_mask & ~(slot_mask_t'(1) << idx)) : cur_mask;
  assign q_pop      = !q_empty && (mask_after == '0);

  always_comb begin
    result_next = '0;
    unique case (idx)
      SLOT_START:  result_next.out_byte = cur.start_byte;
      SLOT_LEN_HI: result_next.out_byte = cur.length[15:8];
      SLOT_LEN_LO: result_next.out_byte = cur.length[7:0];
      SLOT_SEQ:    result_next.out_byte = cur.seq;
      SLOT_CMD:    result_next.out_byte = cur.command;
      SLOT_ESC:    result_next.out_byte = cur.esc_byte;
      SLOT_DATA:   result_next.out_byte = cur.data_byte;
      SLOT_CRC_HI: result_next.out_byte = cur.crc[15:8];
      SLOT_CRC_LO: begin
        result_next.out_byte       = cur.crc[7:0];
        result_next.frame_end      = 1'b1;
        result_next.encoded_length = cur.enc_len;
      end
      SLOT_ERR: begin
        result_next.status    = cur.err_status;
        result_next.frame_end = 1'b1;
      end
      default: result_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask     <= '0;
      result_valid <= 1'b0;
    end else begin
      cur_mask <= q_pop ? q_head.mask : mask_after;
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head.job;
    end
    if (emit) begin
      result <= result_next;
    end
  end

endmodule

[hdl/escaped_frame_encoder_crc16.sv]
// Top level of the byte-stuffing frame encoder with CRC-16 trailer.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-------------------------------------
//  item     | item_valid / item_ready      | item   (cmd, length, command, byte)
//  result   | result_valid / result_ready  | result (byte, status, end, length)
//  cfg      | cfg_valid / cfg_ready        | cfg_index, cfg_data
//
// The front end takes one item per cycle whenever the job queue has room and
// settles all frame state in that cycle. The back end sends one result byte per
// cycle from its output register whenever the result port is not stalled, and an
// item makes as many results as it needs: none for a byte of an aborted frame, 1 to 4
// for a payload byte, 1 for an oversized begin and 5 to 7 for any other begin.
// The single result port sets the sustained rate.
// Reset clears the frame state and queue at once; no clearing pass is needed.
// A stalled result port fills the queue, after which item_ready drops.
module escaped_frame_encoder_crc16 import efe_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Queue between classification and byte emission
  logic   q_full;
  logic   q_push;
  entry_t q_entry;
  logic   q_pop;
  logic   q_empty;
  entry_t q_head;

  // Accept, classify and update frame state
  efe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  // Hold pending jobs so each side can stall on its own
  efe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  // Serialise each job into result transactions
  efe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // A completed frame is at least header plus CRC long
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.frame_end && (result.status == ST_OK))
      |-> (result.encoded_length >= 16'd7))
    else $error("short frame length reported");

  // Error transactions carry a zero byte and close the frame
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status != ST_OK))
      |-> ((result.out_byte == 8'd0) && result.frame_end))
    else $error("malformed error transaction");

  // Mid-frame transactions are plain data with no length
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.frame_end)
      |-> ((result.status == ST_OK) && (result.encoded_length == 16'd0)))
    else $error("mid-frame transaction with status or length");

endmodule
